[hdl/ymrx_pkg.sv]
`default_nettype none

package ymrx_pkg;

    localparam int DUP_WINDOW_DEF       = 8;
    localparam int LONG_BLOCK_BYTES_DEF = 1024;
    localparam int SHORT_BLOCK_BYTES    = 128;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CAN = 8'h18;

    localparam logic [7:0] RP_NONE = 8'h00;
    localparam logic [7:0] RP_ACK  = 8'h06;
    localparam logic [7:0] RP_NAK  = 8'h15;

    localparam logic [2:0] VD_COMMIT  = 3'd0;
    localparam logic [2:0] VD_DUP     = 3'd1;
    localparam logic [2:0] VD_AHEAD   = 3'd2;
    localparam logic [2:0] VD_BAD     = 3'd3;
    localparam logic [2:0] VD_TIMEOUT = 3'd4;
    localparam logic [2:0] VD_EOT     = 3'd5;
    localparam logic [2:0] VD_DONE    = 3'd6;
    localparam logic [2:0] VD_CANCEL  = 3'd7;

    typedef struct packed {
        logic [7:0] reply;
        logic [2:0] verdict;
        logic       keep;
        logic [7:0] out_byte;
        logic       out_kind;
    } ymrx_result_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/ymrx_core.sv]
`default_nettype none

module ymrx_core #(
    parameter int DUP_WINDOW       = ymrx_pkg::DUP_WINDOW_DEF,
    parameter int LONG_BLOCK_BYTES = ymrx_pkg::LONG_BLOCK_BYTES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    input  wire logic                  in_opcode,
    input  wire logic [7:0]            in_byte,
    input  wire logic [31:0]           file_size,
    output logic                       res_valid,
    output ymrx_pkg::ymrx_result_t     res
);

    localparam int IDX_W = $clog2(LONG_BLOCK_BYTES);
    localparam int LEN_W = $clog2(LONG_BLOCK_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_LONG  = LEN_W'(LONG_BLOCK_BYTES);
    localparam logic [LEN_W-1:0] LEN_SHORT = LEN_W'(ymrx_pkg::SHORT_BLOCK_BYTES);
    localparam logic [7:0] DUP_LIMIT = 8'(DUP_WINDOW);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_SEQ  = 3'd1;
    localparam logic [2:0] PH_NSEQ = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRCH = 3'd4;
    localparam logic [2:0] PH_CRCL = 3'd5;

    logic [2:0]       phase_reg, phase_next;
    logic             long_reg, long_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       seq_reg, seq_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crch_reg, crch_next;
    logic [7:0]       exp_reg, exp_next;
    logic [31:0]      bc_reg, bc_next;
    logic             eot_reg, eot_next;

    logic [LEN_W-1:0] len;
    logic [32:0]      pos;
    logic [32:0]      sum;
    logic [LEN_W-1:0] idx_inc;
    logic             do_verdict;
    logic             end_file;
    logic [2:0]       vd;
    logic [7:0]       rp;

    always_comb begin
        len     = long_reg ? LEN_LONG : LEN_SHORT;
        pos     = {1'b0, bc_reg} + 33'(idx_reg);
        sum     = {1'b0, bc_reg} + 33'(len);
        idx_inc = LEN_W'(idx_reg) + LEN_W'(1);

        phase_next = phase_reg;
        long_next  = long_reg;
        idx_next   = idx_reg;
        seq_next   = seq_reg;
        crc_next   = crc_reg;
        crch_next  = crch_reg;
        exp_next   = exp_reg;
        bc_next    = bc_reg;
        eot_next   = eot_reg;

        do_verdict = 1'b0;
        end_file   = 1'b0;
        vd         = ymrx_pkg::VD_COMMIT;
        rp         = ymrx_pkg::RP_NONE;
        res_valid  = 1'b0;
        res        = '0;
        res.out_kind = ymrx_pkg::KIND_VERDICT;

        if (in_opcode == ymrx_pkg::OP_TIMEOUT) begin
            do_verdict = 1'b1;
            vd         = ymrx_pkg::VD_TIMEOUT;
            rp         = ymrx_pkg::RP_NAK;
        end else begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte == ymrx_pkg::CH_SOH || in_byte == ymrx_pkg::CH_STX) begin
                        long_next  = (in_byte == ymrx_pkg::CH_STX);
                        phase_next = PH_SEQ;
                    end else if (in_byte == ymrx_pkg::CH_EOT) begin
                        if (eot_reg) begin
                            do_verdict = 1'b1;
                            vd         = ymrx_pkg::VD_DONE;
                            rp         = ymrx_pkg::RP_ACK;
                        end else begin
                            res_valid   = 1'b1;
                            res.verdict = ymrx_pkg::VD_EOT;
                            res.reply   = ymrx_pkg::RP_NAK;
                            eot_next    = 1'b1;
                        end
                    end else if (in_byte == ymrx_pkg::CH_CAN) begin
                        do_verdict = 1'b1;
                        end_file   = 1'b1;
                        vd         = ymrx_pkg::VD_CANCEL;
                        rp         = ymrx_pkg::RP_NONE;
                    end
                end
                PH_SEQ: begin
                    seq_next   = in_byte;
                    phase_next = PH_NSEQ;
                end
                PH_NSEQ: begin
                    if ((seq_reg ^ in_byte) != 8'hFF) begin
                        do_verdict = 1'b1;
                        vd         = ymrx_pkg::VD_BAD;
                        rp         = ymrx_pkg::RP_NAK;
                    end else begin
                        idx_next   = '0;
                        crc_next   = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    crc_next     = ymrx_pkg::crc_step(crc_reg, in_byte);
                    res_valid    = 1'b1;
                    res.out_kind = ymrx_pkg::KIND_PAYLOAD;
                    res.out_byte = in_byte;
                    res.keep     = (file_size == 32'd0) || (pos < {1'b0, file_size});
                    if (idx_inc >= len) begin
                        idx_next   = '0;
                        phase_next = PH_CRCH;
                    end else begin
                        idx_next   = idx_inc[IDX_W-1:0];
                    end
                end
                PH_CRCH: begin
                    crch_next  = in_byte;
                    phase_next = PH_CRCL;
                end
                PH_CRCL: begin
                    do_verdict = 1'b1;
                    if ({crch_reg, in_byte} != crc_reg) begin
                        vd = ymrx_pkg::VD_BAD;
                        rp = ymrx_pkg::RP_NAK;
                    end else if (eot_reg) begin
                        vd = ymrx_pkg::VD_DONE;
                        rp = ymrx_pkg::RP_ACK;
                    end else if (seq_reg == exp_reg) begin
                        vd       = ymrx_pkg::VD_COMMIT;
                        rp       = ymrx_pkg::RP_ACK;
                        exp_next = exp_reg + 8'd1;
                        if (file_size != 32'd0) begin
                            if (bc_reg >= file_size) begin
                                bc_next = bc_reg;
                            end else if (sum > {1'b0, file_size}) begin
                                bc_next = file_size;
                            end else begin
                                bc_next = sum[31:0];
                            end
                        end else begin
                            bc_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        end
                    end else if (8'(exp_reg - seq_reg) <= DUP_LIMIT) begin
                        vd = ymrx_pkg::VD_DUP;
                        rp = ymrx_pkg::RP_ACK;
                    end else begin
                        vd = ymrx_pkg::VD_AHEAD;
                        rp = ymrx_pkg::RP_NAK;
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end

        if (do_verdict) begin
            phase_next = PH_HUNT;
            if (eot_reg) begin
                end_file = 1'b1;
                vd       = ymrx_pkg::VD_DONE;
                rp       = ymrx_pkg::RP_ACK;
            end
            res_valid    = 1'b1;
            res.out_kind = ymrx_pkg::KIND_VERDICT;
            res.verdict  = vd;
            res.reply    = rp;
        end

        if (end_file) begin
            eot_next = 1'b0;
            exp_next = 8'd1;
            bc_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            long_reg  <= 1'b0;
            idx_reg   <= '0;
            seq_reg   <= '0;
            crc_reg   <= '0;
            crch_reg  <= '0;
            exp_reg   <= 8'd1;
            bc_reg    <= '0;
            eot_reg   <= 1'b0;
        end else if (in_valid) begin
            phase_reg <= phase_next;
            long_reg  <= long_next;
            idx_reg   <= idx_next;
            seq_reg   <= seq_next;
            crc_reg   <= crc_next;
            crch_reg  <= crch_next;
            exp_reg   <= exp_next;
            bc_reg    <= bc_next;
            eot_reg   <= eot_next;
        end
    end

endmodule

`default_nettype wire

[hdl/ymrx_out_buf.sv]
`default_nettype none

module ymrx_out_buf (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   in_valid,
    input  wire ymrx_pkg::ymrx_result_t in_data,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output ymrx_pkg::ymrx_result_t      out_data
);

    logic                   main_valid_reg;
    logic                   skid_valid_reg;
    ymrx_pkg::ymrx_result_t main_reg;
    ymrx_pkg::ymrx_result_t skid_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_ready) begin
                main_reg       <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (in_valid) begin
            if (!main_valid_reg || out_ready) begin
                main_reg       <= in_data;
                main_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= in_data;
                skid_valid_reg <= 1'b1;
            end
        end else if (out_ready) begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire

[hdl/ymodem_block_receiver.sv]
// YMODEM data-phase receiver with CRC-16/XMODEM checking.
// Input stream (s_): one word per received line byte or line timeout event.
//   s_tuser selects the event (0 byte, 1 timeout), s_tdata[7:0] is the byte.
// Output stream (m_): one word per payload byte or per block verdict.
//   m_tuser is the kind (0 payload, 1 verdict); m_tdata carries byte, keep,
//   verdict code and the reply byte to send back to the sender.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the declared file size;
//   write it only while the block is idle. cfg_ready is always high.
// Throughput: one input word per cycle while s_tready is high. The receive state
//   machine and the byte-wide CRC update finish in the accepting cycle; each result
//   word is registered in the output buffer before it appears on m_.
// Reset: aresetn low clears the state machine, file size, sequence tracking
//   and empties both output buffer entries; the block then hunts for a lead byte.
// Stall: a two-entry output buffer holds results while m_tready is low;
//   s_tready drops only when both entries are full.
`default_nettype none

module ymodem_block_receiver #(
    parameter int DUP_WINDOW       = ymrx_pkg::DUP_WINDOW_DEF,
    parameter int LONG_BLOCK_BYTES = ymrx_pkg::LONG_BLOCK_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  wire logic        s_tuser,   // opcode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // out_byte[7:0], keep, verdict[2:0], reply[7:0]
    output logic             m_tuser,   // out_kind
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    logic                   [31:0] file_size_reg;
    logic                   accept;
    logic                   res_valid;
    ymrx_pkg::ymrx_result_t res;
    ymrx_pkg::ymrx_result_t out_res;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            file_size_reg <= cfg_data;
        end
    end

    ymrx_core #(
        .DUP_WINDOW       (DUP_WINDOW),
        .LONG_BLOCK_BYTES (LONG_BLOCK_BYTES)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_opcode (s_tuser),
        .in_byte   (s_tdata),
        .file_size (file_size_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    ymrx_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept && res_valid),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tuser = out_res.out_kind;
    assign m_tdata = {4'b0000, out_res.reply, out_res.verdict, out_res.keep, out_res.out_byte};

endmodule

`default_nettype wire

[verif/ymodem_block_receiver_test.sv]
`timescale 1ns / 100ps

module ymodem_block_receiver_test;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 8;
    localparam int CFG_SETTLE   = 4;
    localparam int RANDOM_WORDS = 8;
    localparam int BURST_MAX    = 16;

    typedef enum logic [2:0] {
        RX_HUNT, RX_SEQ, RX_NSEQ, RX_DATA, RX_CRC_HI, RX_CRC_LO
    } rx_phase_t;

    typedef enum int {
        BLK_GOOD, BLK_BAD_NSEQ, BLK_BAD_CRC, BLK_TIMEOUT_MID
    } blk_fault_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [31:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_ready;

    // receiver state as seen by the scoreboard
    rx_phase_t   p_phase     = RX_HUNT;
    logic        p_long      = 1'b0;
    logic [9:0]  p_index     = '0;
    logic [7:0]  p_seq       = '0;
    logic [15:0] p_crc       = '0;
    logic [7:0]  p_crc_hi    = '0;
    logic [7:0]  p_next_seq  = 8'd1;
    logic [31:0] p_committed = '0;
    logic        p_eot_seen  = 1'b0;
    logic [31:0] p_file_size = '0;

    ymrx_pkg::ymrx_result_t due_results[$];

    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned words_sent    = 0;
    int unsigned ignored_words = 0;
    int          burst_left    = 0;
    int          gap_max       = 0;
    int          stall_pct     = 0;
    int          rx_hold_cycles = 0;
    int          ready_run     = 0;
    logic        ready_level   = 1'b1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    ymodem_block_receiver dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic logic [15:0] crc16_xmodem(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r = {r[14:0], 1'b0};
            if (fb) begin
                r = r ^ ymrx_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void close_file();
        p_eot_seen  = 1'b0;
        p_next_seq  = 8'd1;
        p_committed = '0;
    endfunction

    task automatic post_verdict(input logic [2:0] vd, input logic [7:0] rp);
        ymrx_pkg::ymrx_result_t r;
        p_phase = RX_HUNT;
        if (p_eot_seen) begin
            close_file();
            vd = ymrx_pkg::VD_DONE;
            rp = ymrx_pkg::RP_ACK;
        end
        r = '0;
        r.out_kind = ymrx_pkg::KIND_VERDICT;
        r.verdict  = vd;
        r.reply    = rp;
        due_results.push_back(r);
    endtask

    task automatic decode_line_word(input logic op, input logic [7:0] b);
        ymrx_pkg::ymrx_result_t r;
        logic [32:0]  pos;
        logic [32:0]  room;
        logic [32:0]  add;
        logic [32:0]  sum;
        int unsigned  blen;
        blen = p_long ? ymrx_pkg::LONG_BLOCK_BYTES_DEF : ymrx_pkg::SHORT_BLOCK_BYTES;
        if (op == ymrx_pkg::OP_TIMEOUT) begin
            post_verdict(ymrx_pkg::VD_TIMEOUT, ymrx_pkg::RP_NAK);
            return;
        end
        case (p_phase)
            RX_HUNT: begin
                if (b == ymrx_pkg::CH_SOH || b == ymrx_pkg::CH_STX) begin
                    p_long  = (b == ymrx_pkg::CH_STX);
                    p_phase = RX_SEQ;
                end else if (b == ymrx_pkg::CH_EOT) begin
                    if (p_eot_seen) begin
                        post_verdict(ymrx_pkg::VD_DONE, ymrx_pkg::RP_ACK);
                    end else begin
                        r = '0;
                        r.out_kind = ymrx_pkg::KIND_VERDICT;
                        r.verdict  = ymrx_pkg::VD_EOT;
                        r.reply    = ymrx_pkg::RP_NAK;
                        due_results.push_back(r);
                        p_eot_seen = 1'b1;
                    end
                end else if (b == ymrx_pkg::CH_CAN) begin
                    if (!p_eot_seen) begin
                        close_file();
                    end
                    post_verdict(ymrx_pkg::VD_CANCEL, ymrx_pkg::RP_NONE);
                end
            end
            RX_SEQ: begin
                p_seq   = b;
                p_phase = RX_NSEQ;
            end
            RX_NSEQ: begin
                if ((p_seq ^ b) != 8'hFF) begin
                    post_verdict(ymrx_pkg::VD_BAD, ymrx_pkg::RP_NAK);
                end else begin
                    p_index = '0;
                    p_crc   = '0;
                    p_phase = RX_DATA;
                end
            end
            RX_DATA: begin
                pos   = {1'b0, p_committed} + 33'(p_index);
                p_crc = crc16_xmodem(p_crc, b);
                r = '0;
                r.out_kind = ymrx_pkg::KIND_PAYLOAD;
                r.out_byte = b;
                r.keep     = (p_file_size == 32'd0) || (pos < {1'b0, p_file_size});
                due_results.push_back(r);
                if (32'(p_index) + 32'd1 >= blen) begin
                    p_index = '0;
                    p_phase = RX_CRC_HI;
                end else begin
                    p_index = p_index + 10'd1;
                end
            end
            RX_CRC_HI: begin
                p_crc_hi = b;
                p_phase  = RX_CRC_LO;
            end
            RX_CRC_LO: begin
                if ({p_crc_hi, b} != p_crc) begin
                    post_verdict(ymrx_pkg::VD_BAD, ymrx_pkg::RP_NAK);
                end else if (p_eot_seen) begin
                    post_verdict(ymrx_pkg::VD_DONE, ymrx_pkg::RP_ACK);
                end else if (p_seq == p_next_seq) begin
                    add = 33'(blen);
                    if (p_file_size != 32'd0) begin
                        room = (p_committed >= p_file_size) ? 33'd0
                             : {1'b0, p_file_size} - {1'b0, p_committed};
                        if (add > room) begin
                            add = room;
                        end
                    end
                    sum = {1'b0, p_committed} + add;
                    p_committed = (sum > 33'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
                    p_next_seq  = p_next_seq + 8'd1;
                    post_verdict(ymrx_pkg::VD_COMMIT, ymrx_pkg::RP_ACK);
                end else if (8'(p_next_seq - p_seq) <= 8'(ymrx_pkg::DUP_WINDOW_DEF)) begin
                    post_verdict(ymrx_pkg::VD_DUP, ymrx_pkg::RP_ACK);
                end else begin
                    post_verdict(ymrx_pkg::VD_AHEAD, ymrx_pkg::RP_NAK);
                end
            end
            default: begin
                p_phase = RX_HUNT;
            end
        endcase
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge aclk) begin : check_results
        ymrx_pkg::ymrx_result_t head;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("result word with nothing due: tuser %0b tdata %0h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                head = due_results.pop_front();
                check_field("out_kind", head.out_kind, m_tuser);
                check_field("out_byte", head.out_byte, m_tdata[7:0]);
                check_field("keep",     head.keep,     m_tdata[8]);
                check_field("verdict",  head.verdict,  m_tdata[11:9]);
                check_field("reply",    head.reply,    m_tdata[19:12]);
            end
        end
    end

    always @(posedge aclk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles = rx_hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            if (ready_run == 0) begin
                ready_level = ($urandom_range(99, 0) >= stall_pct);
                ready_run   = $urandom_range(6, 1);
            end
            ready_run = ready_run - 1;
            m_tready <= ready_level;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic [7:0] b);
        int   gap;
        logic taken;
        if (burst_left == 0) begin
            gap = $urandom_range(gap_max, 0);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(BURST_MAX, 1);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = s_tready;
            if (taken) begin
                decode_line_word(op, b);
            end
            @(posedge aclk);
        end
        words_sent++;
    endtask

    task automatic send_junk(input int n);
        logic [7:0] b;
        repeat (n) begin
            do begin
                b = 8'($urandom_range(255, 0));
            end while (b == ymrx_pkg::CH_SOH || b == ymrx_pkg::CH_STX ||
                       b == ymrx_pkg::CH_EOT || b == ymrx_pkg::CH_CAN);
            send_word(ymrx_pkg::OP_BYTE, b);
            ignored_words++;
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
        repeat (CFG_SETTLE) @(posedge aclk);
    endtask

    task automatic reconfigure(input logic [31:0] fsize);
        logic taken;
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= fsize;
        taken = 1'b0;
        while (!taken) begin
            @(negedge aclk);
            taken = cfg_ready;
            if (taken) begin
                p_file_size = fsize;
            end
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_block(input logic long_blk, input logic [7:0] seq,
                              input blk_fault_t fault);
        int unsigned blen;
        int unsigned cut;
        logic [15:0] crc;
        logic [7:0]  d;
        blen = long_blk ? ymrx_pkg::LONG_BLOCK_BYTES_DEF : ymrx_pkg::SHORT_BLOCK_BYTES;
        send_word(ymrx_pkg::OP_BYTE, long_blk ? ymrx_pkg::CH_STX : ymrx_pkg::CH_SOH);
        send_word(ymrx_pkg::OP_BYTE, seq);
        if (fault == BLK_BAD_NSEQ) begin
            send_word(ymrx_pkg::OP_BYTE, ~seq ^ (8'h01 << $urandom_range(7, 0)));
            send_junk($urandom_range(3, 0));
            return;
        end
        send_word(ymrx_pkg::OP_BYTE, ~seq);
        cut = (fault == BLK_TIMEOUT_MID) ? $urandom_range(blen + 1, 0) : blen + 2;
        crc = '0;
        for (int unsigned i = 0; i < blen; i++) begin
            if (i == cut) begin
                send_word(ymrx_pkg::OP_TIMEOUT, 8'($urandom_range(255, 0)));
                return;
            end
            d   = 8'($urandom_range(255, 0));
            crc = crc16_xmodem(crc, d);
            send_word(ymrx_pkg::OP_BYTE, d);
        end
        if (fault == BLK_BAD_CRC) begin
            crc = crc ^ (16'h0001 << $urandom_range(15, 0));
        end
        if (cut == blen) begin
            send_word(ymrx_pkg::OP_TIMEOUT, 8'($urandom_range(255, 0)));
            return;
        end
        send_word(ymrx_pkg::OP_BYTE, crc[15:8]);
        if (cut == blen + 1) begin
            send_word(ymrx_pkg::OP_TIMEOUT, 8'($urandom_range(255, 0)));
            return;
        end
        send_word(ymrx_pkg::OP_BYTE, crc[7:0]);
    endtask

    function automatic logic [7:0] pick_seq();
        int r;
        r = $urandom_range(99, 0);
        if (r < 60) begin
            return p_next_seq;
        end else if (r < 80) begin
            return p_next_seq - 8'($urandom_range(ymrx_pkg::DUP_WINDOW_DEF, 1));
        end else if (r < 90) begin
            return p_next_seq - 8'($urandom_range(ymrx_pkg::DUP_WINDOW_DEF + 4,
                                                  ymrx_pkg::DUP_WINDOW_DEF + 1));
        end
        return 8'($urandom_range(255, 0));
    endfunction

    function automatic blk_fault_t pick_fault();
        int r;
        r = $urandom_range(99, 0);
        if (r < 70) begin
            return BLK_GOOD;
        end else if (r < 80) begin
            return BLK_BAD_NSEQ;
        end else if (r < 90) begin
            return BLK_BAD_CRC;
        end
        return BLK_TIMEOUT_MID;
    endfunction

    task automatic test_line_events();
        gap_max   = 0;
        stall_pct = 0;
        send_word(ymrx_pkg::OP_BYTE, 8'h00);
        send_word(ymrx_pkg::OP_BYTE, 8'hFF);
        send_word(ymrx_pkg::OP_TIMEOUT, ymrx_pkg::CH_SOH);
        // end of file, then any outcome closes the file
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
        send_word(ymrx_pkg::OP_TIMEOUT, 8'hFF);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_CAN);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_CAN);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_SOH);
        send_word(ymrx_pkg::OP_BYTE, 8'h01);
        send_word(ymrx_pkg::OP_BYTE, 8'h01);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_STX);
        send_word(ymrx_pkg::OP_BYTE, 8'hFF);
        send_word(ymrx_pkg::OP_BYTE, 8'h01);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_SOH);
        send_word(ymrx_pkg::OP_BYTE, 8'h00);
        send_word(ymrx_pkg::OP_BYTE, 8'h00);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_SOH);
        send_word(ymrx_pkg::OP_TIMEOUT, 8'h00);
    endtask

    task automatic test_file_trim();
        gap_max   = 3;
        stall_pct = 30;
        // size below what is already committed
        reconfigure(32'd900);
        send_block(1'b0, p_next_seq, BLK_GOOD);
        send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
        send_block(1'b0, p_next_seq, BLK_BAD_NSEQ);
    endtask

    task automatic test_long_block_backpressure();
        reconfigure(32'd1000);
        gap_max        = 0;
        stall_pct      = 0;
        rx_hold_cycles = 400;
        send_block(1'b1, p_next_seq, BLK_GOOD);
    endtask

    task automatic test_random_traffic();
        logic [31:0] fsize;
        int          pick;
        int unsigned base;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    fsize = 32'd0;
                    gap_max = 0;
                    stall_pct = 0;
                end
                1: begin
                    fsize = 32'($urandom_range(600, 1));
                    gap_max = 6;
                    stall_pct = 50;
                end
                default: begin
                    fsize = 32'd1;
                    gap_max = 2;
                    stall_pct = 70;
                end
            endcase
            reconfigure(fsize);
            base = words_sent - ignored_words;
            while (words_sent - ignored_words - base < RANDOM_WORDS) begin
                pick = $urandom_range(99, 0);
                if (pick < 65) begin
                    send_block(1'b0, pick_seq(), pick_fault());
                end else if (pick < 77) begin
                    send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_EOT);
                end else if (pick < 86) begin
                    send_word(ymrx_pkg::OP_TIMEOUT, 8'($urandom_range(255, 0)));
                end else if (pick < 91) begin
                    send_word(ymrx_pkg::OP_BYTE, ymrx_pkg::CH_CAN);
                end else begin
                    send_junk($urandom_range(4, 1));
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_line_events();
        test_long_block_backpressure();
        test_file_trim();
        test_random_traffic();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
